@@ rtl/core/hsm_pkg.sv @@
package hsm_pkg;

  localparam int TableEntries = 16;
  localparam int MaxSeqKeys   = 4;

  localparam int KeyW  = 29;
  localparam int CodeW = 25;
  localparam int ModW  = 4;
  localparam int LenW  = 3;
  localparam int ActW  = 8;
  localparam int TickW = 16;

  localparam logic [TickW-1:0] TimeoutReset = 16'd1000;

  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_REG   = 2'd2,
    REQ_UNREG = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_TRIGGERED = 4'd1,
    ST_PARTIAL   = 4'd2,
    ST_REGISTERED = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_CONFLICT  = 4'd5,
    ST_FULL      = 4'd6,
    ST_REMOVED   = 4'd7,
    ST_NOT_FOUND = 4'd8
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [CodeW-1:0]  key_code;
    logic              pressed;
    logic [ModW-1:0]   modifiers;
    logic [LenW-1:0]   seq_len;
    key_t              seq_key0;
    key_t              seq_key1;
    key_t              seq_key2;
    key_t              seq_key3;
    logic [ActW-1:0]   action_id;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic             handled;
    logic [ActW-1:0]  matched_action;
    logic [ActW-1:0]  conflict_action;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctrl_t;

  typedef struct packed {
    logic vld;
    logic live;
  } tbl_rsp_t;

  typedef struct packed {
    logic exact;
    logic prefix;
  } cmp_t;

endpackage

@@ rtl/core/hsm_cmp.sv @@
module hsm_cmp #(
  parameter int MAX_SEQ_KEYS = hsm_pkg::MaxSeqKeys
) (
  input  logic                                 live_i,
  input  logic [hsm_pkg::LenW-1:0]             row_len_i,
  input  hsm_pkg::key_t [MAX_SEQ_KEYS-1:0]     row_keys_i,
  input  logic [hsm_pkg::LenW-1:0]             probe_len_i,
  input  hsm_pkg::key_t [MAX_SEQ_KEYS-1:0]     probe_keys_i,
  output hsm_pkg::cmp_t                        cmp_o
);
  import hsm_pkg::*;

  logic [MAX_SEQ_KEYS-1:0] same;

  // keys at or past the probe length do not take part
  always_comb begin
    for (int i = 0; i < MAX_SEQ_KEYS; i++) begin
      same[i] = (LenW'(i) >= probe_len_i) || (row_keys_i[i] == probe_keys_i[i]);
    end
  end

  assign cmp_o.exact  = live_i && (row_len_i == probe_len_i) && (&same);
  assign cmp_o.prefix = live_i && (row_len_i > probe_len_i) && (&same);

endmodule

@@ rtl/core/hsm_table.sv @@
module hsm_table #(
  parameter int TABLE_ENTRIES = hsm_pkg::TableEntries,
  parameter int MAX_SEQ_KEYS  = hsm_pkg::MaxSeqKeys,
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hsm_pkg::tbl_ctrl_t                ctrl_i,
  input  logic [IdxW-1:0]                   rd_idx_i,
  input  logic [IdxW-1:0]                   wr_idx_i,
  input  logic [IdxW-1:0]                   clr_idx_i,
  input  logic [hsm_pkg::LenW-1:0]          wr_len_i,
  input  hsm_pkg::key_t [MAX_SEQ_KEYS-1:0]  wr_keys_i,
  input  logic [hsm_pkg::ActW-1:0]          wr_act_i,
  output hsm_pkg::tbl_rsp_t                 rsp_o,
  output logic [IdxW-1:0]                   rsp_idx_o,
  output logic [hsm_pkg::LenW-1:0]          rsp_len_o,
  output hsm_pkg::key_t [MAX_SEQ_KEYS-1:0]  rsp_keys_o,
  output logic [hsm_pkg::ActW-1:0]          rsp_act_o
);
  import hsm_pkg::*;

  localparam int RowW = LenW + MAX_SEQ_KEYS * KeyW + ActW;

  logic [RowW-1:0]          mem_q [TABLE_ENTRIES];
  logic [RowW-1:0]          row_q;
  logic [IdxW-1:0]          idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     rsp_vld_q;
  logic                     live_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_idx_i] <= {wr_len_i, wr_keys_i, wr_act_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      row_q <= mem_q[rd_idx_i];
      idx_q <= rd_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rsp_vld_q <= 1'b0;
      live_q    <= 1'b0;
    end else begin
      rsp_vld_q <= ctrl_i.rd_en;
      if (ctrl_i.rd_en) begin
        live_q <= valid_q[rd_idx_i];
      end
      if (ctrl_i.wr_en) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (ctrl_i.clr_en) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  assign rsp_o.vld  = rsp_vld_q;
  assign rsp_o.live = live_q;
  assign rsp_idx_o  = idx_q;
  assign {rsp_len_o, rsp_keys_o, rsp_act_o} = row_q;

endmodule

@@ rtl/core/hotkey_sequence_matcher.sv @@
// Hotkey sequence matcher. A request is taken when start is high and busy is low; its
// single result word shows on res_o for exactly one cycle with done_o high, and the
// receiver cannot stall it. Time ticks, key releases, key presses that find the pending
// sequence full, and requests rejected for their length or action show their result the
// cycle after acceptance and leave busy low. All other key presses, register and
// unregister requests walk the shortcut table one entry per cycle through the table's
// single read port; busy stays high while the table is walked and the result is formed,
// so no new request is taken until that result shows. The timeout register may be
// written at any idle time; a value of zero acts as one.
module hotkey_sequence_matcher #(
  parameter int TABLE_ENTRIES = hsm_pkg::TableEntries,
  parameter int MAX_SEQ_KEYS  = hsm_pkg::MaxSeqKeys
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  hsm_pkg::req_t              req_i,
  output logic                       done_o,
  output hsm_pkg::res_t              res_o,
  input  logic                       cfg_we_i,
  input  logic [hsm_pkg::TickW-1:0]  cfg_wdata_i
);
  import hsm_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  req_e   op_q, op_d;

  logic [LenW-1:0]  plen_q, plen_d;
  key_t [MAX_SEQ_KEYS-1:0] seq_q, seq_d;
  logic [ActW-1:0]  act_q, act_d;
  logic [CntW-1:0]  iss_q, iss_d;

  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [ActW-1:0]  hit_act_q, hit_act_d;
  logic             pre_q, pre_d;
  logic             free_q, free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;

  key_t [MAX_SEQ_KEYS-1:0] pend_q, pend_d;
  logic [LenW-1:0]  pend_cnt_q, pend_cnt_d;
  logic [TickW-1:0] timer_q, timer_d;
  logic [TickW-1:0] ticks_q;

  res_t res_q, res_d;
  logic done_q, done_d;

  key_t [3:0]               in_keys;
  key_t                     new_key;
  logic                     len_ok;
  key_t [MAX_SEQ_KEYS-1:0]  probe_keys;
  logic [LenW-1:0]          probe_len;

  tbl_ctrl_t               tbl_ctrl;
  tbl_rsp_t                tbl_rsp;
  logic [IdxW-1:0]         rsp_idx;
  logic [LenW-1:0]         rsp_len;
  key_t [MAX_SEQ_KEYS-1:0] rsp_keys;
  logic [ActW-1:0]         rsp_act;
  cmp_t                    cmp;

  assign in_keys = {req_i.seq_key3, req_i.seq_key2, req_i.seq_key1, req_i.seq_key0};
  assign new_key = {req_i.modifiers, req_i.key_code};
  assign len_ok  = (req_i.seq_len != '0) && (req_i.seq_len <= LenW'(MAX_SEQ_KEYS));

  assign probe_keys = (op_q == REQ_KEY) ? pend_q : seq_q;
  assign probe_len  = (op_q == REQ_KEY) ? pend_cnt_q : plen_q;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  hsm_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SEQ_KEYS  (MAX_SEQ_KEYS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tbl_ctrl),
    .rd_idx_i   (iss_q[IdxW-1:0]),
    .wr_idx_i   (free_idx_q),
    .clr_idx_i  (hit_idx_q),
    .wr_len_i   (plen_q),
    .wr_keys_i  (seq_q),
    .wr_act_i   (act_q),
    .rsp_o      (tbl_rsp),
    .rsp_idx_o  (rsp_idx),
    .rsp_len_o  (rsp_len),
    .rsp_keys_o (rsp_keys),
    .rsp_act_o  (rsp_act)
  );

  hsm_cmp #(
    .MAX_SEQ_KEYS (MAX_SEQ_KEYS)
  ) u_cmp (
    .live_i       (tbl_rsp.live),
    .row_len_i    (rsp_len),
    .row_keys_i   (rsp_keys),
    .probe_len_i  (probe_len),
    .probe_keys_i (probe_keys),
    .cmp_o        (cmp)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    plen_d     = plen_q;
    seq_d      = seq_q;
    act_d      = act_q;
    iss_d      = iss_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_act_d  = hit_act_q;
    pre_d      = pre_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    timer_d    = timer_q;
    res_d      = '{status: ST_NONE, handled: 1'b0, matched_action: '0, conflict_action: '0};
    done_d     = 1'b0;
    tbl_ctrl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = req_i.req_type;
          plen_d     = req_i.seq_len;
          act_d      = req_i.action_id;
          iss_d      = '0;
          hit_d      = 1'b0;
          hit_idx_d  = '0;
          hit_act_d  = '0;
          pre_d      = 1'b0;
          free_d     = 1'b0;
          free_idx_d = '0;
          for (int i = 0; i < MAX_SEQ_KEYS; i++) begin
            seq_d[i] = in_keys[i];
          end
          case (req_i.req_type)
            REQ_KEY: begin
              if (!req_i.pressed) begin
                done_d = 1'b1;
              end else if (pend_cnt_q >= LenW'(MAX_SEQ_KEYS)) begin
                pend_d     = '0;
                pend_cnt_d = '0;
                timer_d    = '0;
                done_d     = 1'b1;
              end else begin
                for (int i = 0; i < MAX_SEQ_KEYS; i++) begin
                  if (pend_cnt_q == LenW'(i)) begin
                    pend_d[i] = new_key;
                  end
                end
                pend_cnt_d = pend_cnt_q + LenW'(1);
                timer_d    = (ticks_q == '0) ? TickW'(1) : ticks_q;
                state_d    = S_SCAN;
              end
            end
            REQ_TICK: begin
              if (timer_q != '0) begin
                timer_d = timer_q - TickW'(1);
                if (timer_q == TickW'(1)) begin
                  pend_d     = '0;
                  pend_cnt_d = '0;
                end
              end
              done_d = 1'b1;
            end
            REQ_REG: begin
              if (!len_ok || (req_i.action_id == '0)) begin
                res_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            REQ_UNREG: begin
              if (!len_ok) begin
                res_d.status = ST_NOT_FOUND;
                done_d       = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (iss_q != CntW'(TABLE_ENTRIES)) begin
          tbl_ctrl.rd_en = 1'b1;
          iss_d          = iss_q + CntW'(1);
        end
        if (tbl_rsp.vld) begin
          if (cmp.exact && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rsp_idx;
            hit_act_d = rsp_act;
          end
          if (cmp.prefix) begin
            pre_d = 1'b1;
          end
          if (!tbl_rsp.live && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rsp_idx;
          end
          if (rsp_idx == IdxW'(TABLE_ENTRIES - 1)) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          REQ_KEY: begin
            if (hit_q) begin
              res_d.status         = ST_TRIGGERED;
              res_d.handled        = 1'b1;
              res_d.matched_action = hit_act_q;
              pend_d               = '0;
              pend_cnt_d           = '0;
              timer_d              = '0;
            end else if (pre_q) begin
              res_d.status  = ST_PARTIAL;
              res_d.handled = 1'b1;
            end else begin
              pend_d     = '0;
              pend_cnt_d = '0;
              timer_d    = '0;
            end
          end
          REQ_REG: begin
            if (hit_q) begin
              if (hit_act_q != act_q) begin
                res_d.status          = ST_CONFLICT;
                res_d.conflict_action = hit_act_q;
              end else begin
                res_d.status = ST_REGISTERED;
              end
            end else if (free_q) begin
              tbl_ctrl.wr_en = 1'b1;
              res_d.status   = ST_REGISTERED;
            end else begin
              res_d.status = ST_FULL;
            end
          end
          REQ_UNREG: begin
            if (hit_q) begin
              tbl_ctrl.clr_en = 1'b1;
              res_d.status    = ST_REMOVED;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          default: begin
            res_d.status = ST_NONE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= REQ_KEY;
      iss_q      <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_act_q  <= '0;
      pre_q      <= 1'b0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      pend_q     <= '0;
      pend_cnt_q <= '0;
      timer_q    <= '0;
      ticks_q    <= TimeoutReset;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      iss_q      <= iss_d;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      hit_act_q  <= hit_act_d;
      pre_q      <= pre_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
      timer_q    <= timer_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  // request payload and result word
  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
    seq_q  <= seq_d;
    act_q  <= act_d;
    res_q  <= res_d;
  end

endmodule
